/* hdl/byte_ring_fifo_burst_unit_defines.svh */
// assertion macros used by the byte ring fifo checker
`ifndef BYTE_RING_FIFO_BURST_UNIT_DEFINES_SVH
`define BYTE_RING_FIFO_BURST_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brf assertion failed");

// next-cycle implication that also holds through reset
`define BRF_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("brf assertion failed");

`endif

/* hdl/brf_pkg.sv */
// constants and widths for the byte ring fifo burst unit
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int MAX_BURST = 8;
  localparam int NUM_BANKS = 8;
  localparam int BANK_BITS = 3;
  localparam int LANE_W    = 8;
  localparam int DATA_W    = NUM_BANKS * LANE_W;
  localparam int COUNT_W   = 4;
  localparam int FILL_W    = 9;
  localparam int CAP_W     = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

endpackage

`default_nettype wire

/* hdl/brf_channels_if.sv */
// request and result channel interfaces of the byte ring fifo
`timescale 1ns / 1ps
`default_nettype none

interface brf_in_if import brf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [COUNT_W-1:0] byte_count;
  logic [DATA_W-1:0]  push_bytes;

  modport source (output valid, action, byte_count, push_bytes, input ready);
  modport sink   (input valid, action, byte_count, push_bytes, output ready);
endinterface

interface brf_out_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [DATA_W-1:0] pop_bytes;
  logic [FILL_W-1:0] fill_level;

  modport source (output valid, accepted, pop_bytes, fill_level, input ready);
  modport sink   (input valid, accepted, pop_bytes, fill_level, output ready);
endinterface

`default_nettype wire

/* hdl/byte_ring_fifo_burst_unit.sv */
// an accepted request passes the read stage register, then the result register, before its result goes valid
// throughput: one transaction per cycle while the result side is ready
// a stalled result holds the input once two transactions are in flight
// reset clears pointers, fill count, result valids and sets capacity to 256
// the byte banks are not cleared; a capacity write empties the ring
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_burst_unit
  import brf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  brf_in_if.sink           in_chan,
  brf_out_if.source        out_chan,
  input  wire              cfg_we,
  input  wire [CAP_W-1:0]  cfg_wdata
);

  localparam int CW       = $clog2(DEPTH + 1);
  localparam int FW       = (CW > FILL_W) ? CW : FILL_W;
  localparam int ROWS_MIN = (DEPTH + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROW_BITS = ($clog2(ROWS_MIN) < 1) ? 1 : $clog2(ROWS_MIN);
  localparam int ROWS     = 1 << ROW_BITS;
  localparam int AW       = ROW_BITS + BANK_BITS;

  typedef struct packed {
    logic                 accepted;
    logic                 pop;
    logic [COUNT_W-1:0]   count;
    logic [BANK_BITS-1:0] rot;
    logic [FILL_W-1:0]    fill_level;
  } s1_t;

  logic [CAP_W-1:0] cap_r;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;

  logic             s1_valid_r;
  s1_t              s1_r, s1_nxt;
  logic             out_valid_r;
  logic             out_accepted_r;
  logic [DATA_W-1:0] out_pop_r, out_pop_nxt;
  logic [FILL_W-1:0] out_fill_r;

  logic [FW-1:0] cap_wide, cap_sel, fill_wide, free_wide, cnt_wide, fill_after;
  logic          is_push, fill_ok, req_ok, in_fire, commit, out_free, s1_move;

  logic [LANE_W-1:0]    push_lane [NUM_BANKS];
  logic [BANK_BITS-1:0] wlane     [NUM_BANKS];
  logic [BANK_BITS-1:0] rlane     [NUM_BANKS];
  logic [AW-1:0]        waddr     [NUM_BANKS];
  logic [AW-1:0]        raddr     [NUM_BANKS];
  logic                 bank_we   [NUM_BANKS];
  logic                 bank_re   [NUM_BANKS];
  logic [LANE_W-1:0]    rd_data_r [NUM_BANKS];

  // capacity and free space
  assign cap_wide  = FW'(cap_r);
  assign cap_sel   = (cap_r == '0 || cap_wide > FW'(DEPTH)) ? FW'(DEPTH) : cap_wide;
  assign fill_wide = FW'(fill_r);
  assign free_wide = cap_sel - fill_wide;
  assign cnt_wide  = FW'(in_chan.byte_count);
  assign fill_ok   = fill_wide <= cap_sel;
  assign is_push   = in_chan.action == ACT_PUSH;

  always_comb begin
    req_ok = 1'b0;
    if (in_chan.byte_count <= COUNT_W'(MAX_BURST)) begin
      if (is_push) begin
        req_ok = fill_ok && (cnt_wide <= free_wide);
      end else begin
        req_ok = cnt_wide <= fill_wide;
      end
    end
  end

  assign out_free       = !out_valid_r || out_chan.ready;
  assign s1_move        = s1_valid_r && out_free;
  assign in_chan.ready  = !s1_valid_r || out_free;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign commit         = in_fire && req_ok;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    if (is_push) begin
      wr_ptr_nxt = wr_ptr_r + AW'(in_chan.byte_count);
      fill_nxt   = fill_r + CW'(in_chan.byte_count);
    end else begin
      rd_ptr_nxt = rd_ptr_r + AW'(in_chan.byte_count);
      fill_nxt   = fill_r - CW'(in_chan.byte_count);
    end
  end

  assign fill_after = commit ? FW'(fill_nxt) : fill_wide;

  always_comb begin
    s1_nxt.accepted   = req_ok;
    s1_nxt.pop        = !is_push;
    s1_nxt.count      = in_chan.byte_count;
    s1_nxt.rot        = rd_ptr_r[BANK_BITS-1:0];
    s1_nxt.fill_level = fill_after[FILL_W-1:0];
  end

  // ring state and capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (cfg_we) begin
      cap_r    <= cfg_wdata;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (commit) begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // byte banks, consecutive ring bytes land in consecutive banks
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [LANE_W-1:0] bank_mem_r [ROWS];

    assign push_lane[b] = in_chan.push_bytes[b*LANE_W +: LANE_W];
    assign wlane[b]     = BANK_BITS'(b) - wr_ptr_r[BANK_BITS-1:0];
    assign rlane[b]     = BANK_BITS'(b) - rd_ptr_r[BANK_BITS-1:0];
    assign waddr[b]     = wr_ptr_r + AW'(wlane[b]);
    assign raddr[b]     = rd_ptr_r + AW'(rlane[b]);
    assign bank_we[b]   = commit && is_push && (COUNT_W'(wlane[b]) < in_chan.byte_count);
    assign bank_re[b]   = commit && !is_push && (COUNT_W'(rlane[b]) < in_chan.byte_count);

    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        bank_mem_r[waddr[b][AW-1:BANK_BITS]] <= push_lane[wlane[b]];
      end
      if (bank_re[b]) begin
        rd_data_r[b] <= bank_mem_r[raddr[b][AW-1:BANK_BITS]];
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  // realign popped bytes so the oldest lands in lane zero
  always_comb begin
    logic [BANK_BITS-1:0] idx;
    out_pop_nxt = '0;
    for (int i = 0; i < NUM_BANKS; i++) begin
      idx = s1_r.rot + BANK_BITS'(i);
      if (s1_r.accepted && s1_r.pop && (COUNT_W'(i) < s1_r.count)) begin
        out_pop_nxt[i*LANE_W +: LANE_W] = rd_data_r[idx];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_accepted_r <= s1_r.accepted;
      out_pop_r      <= out_pop_nxt;
      out_fill_r     <= s1_r.fill_level;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.accepted   = out_accepted_r;
  assign out_chan.pop_bytes  = out_pop_r;
  assign out_chan.fill_level = out_fill_r;

endmodule

`default_nettype wire

/* hdl/brf_checker.sv */
// port-level checks for the byte ring fifo burst unit and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "byte_ring_fifo_burst_unit_defines.svh"

module brf_checker
  import brf_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire              out_accepted,
  input wire [DATA_W-1:0] out_pop_bytes,
  input wire [FILL_W-1:0] out_fill_level
);

  // a rejected transaction never carries data
  `BRF_ASSERT_IMP(a_reject_no_data, clk, rst_n, out_valid && !out_accepted, out_pop_bytes == '0)

  // drained result side never blocks a new request
  `BRF_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_valid, in_ready)

  // stalled result holds
  `BRF_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pop_bytes) && $stable(out_accepted) && $stable(out_fill_level))

  // reset drops any pending result
  `BRF_ASSERT_ALWAYS_NXT(a_reset_clears, clk, !rst_n, !out_valid)

endmodule

bind byte_ring_fifo_burst_unit brf_checker u_brf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_accepted   (out_chan.accepted),
  .out_pop_bytes  (out_chan.pop_bytes),
  .out_fill_level (out_chan.fill_level)
);

`default_nettype wire
